### rtl/core/ttl_lcd_pkg.sv
// ttl_lcd_pkg: widths, codes, request/response and control types for the cache directory
// used by every file of the block; no dependencies

package ttl_lcd_pkg;

   localparam int ENTRIES_DEF    = 256;
   localparam int VALUE_MAX_DEF  = 4096;
   localparam int PARTITIONS_DEF = 6;

   localparam int MASK_W   = 6;
   localparam int KEY_W    = 64;
   localparam int TIME_W   = 48;
   localparam int TTL_W    = 32;
   localparam int LEN_W    = 13;
   localparam int SLOT_W   = 8;
   localparam int STAT_W   = 64;
   localparam int PART_W   = 3;
   localparam int NUM_CNT  = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic [2:0] op_type;
   localparam op_type OP_LOOKUP  = 3'd0;
   localparam op_type OP_STORE   = 3'd1;
   localparam op_type OP_CLEAR   = 3'd2;
   localparam op_type OP_STAT    = 3'd3;
   localparam op_type OP_REFRESH = 3'd4;

   typedef logic [3:0] status_type;
   localparam status_type ST_HIT      = 4'd0;
   localparam status_type ST_MISS     = 4'd1;
   localparam status_type ST_EXPIRED  = 4'd2;
   localparam status_type ST_SMALL    = 4'd3;
   localparam status_type ST_UPDATED  = 4'd4;
   localparam status_type ST_NEW      = 4'd5;
   localparam status_type ST_EVICTED  = 4'd6;
   localparam status_type ST_REJECTED = 4'd7;
   localparam status_type ST_CLEARED  = 4'd8;
   localparam status_type ST_STAT     = 4'd9;
   localparam status_type ST_REFRESH  = 4'd10;

   typedef logic [2:0] sel_type;
   localparam sel_type CNT_HITS          = 3'd0;
   localparam sel_type CNT_MISSES        = 3'd1;
   localparam sel_type CNT_STORES        = 3'd2;
   localparam sel_type CNT_EXPIRATIONS   = 3'd3;
   localparam sel_type CNT_EVICTIONS     = 3'd4;
   localparam sel_type CNT_INVALIDATIONS = 3'd5;
   localparam sel_type CNT_REFRESHES     = 3'd6;
   localparam sel_type SEL_LIVE          = 3'd7;

   localparam logic CSR_IDX_ENABLE = 1'b0;
   localparam logic CSR_IDX_MASK   = 1'b1;

   typedef struct packed {
      op_type              opcode;
      logic [PART_W-1:0]   partition;
      logic                clear_all;
      logic [KEY_W-1:0]    key_tag;
      logic [TIME_W-1:0]   now_ms;
      logic [TTL_W-1:0]    ttl_ms;
      logic [LEN_W-1:0]    byte_length;
      sel_type             stat_select;
      logic                reset_after_read;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [LEN_W-1:0]    stored_length;
      logic [STAT_W-1:0]   stat_value;
   } rsp_type;

   typedef struct packed {
      logic [PART_W-1:0]   part;
      logic [KEY_W-1:0]    key;
      logic [LEN_W-1:0]    len;
      logic [TIME_W-1:0]   expiry;
      logic [STAT_W-1:0]   stamp;
   } row_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/ttl_lcd_req_if.sv
// ttl_lcd_req_if: request channel, valid/ready with the request fields
// depends on ttl_lcd_pkg

interface ttl_lcd_req_if;
   import ttl_lcd_pkg::*;

   logic                valid;
   logic                ready;
   logic [2:0]          opcode;
   logic [PART_W-1:0]   partition;
   logic                clear_all;
   logic [KEY_W-1:0]    key_tag;
   logic [TIME_W-1:0]   now_ms;
   logic [TTL_W-1:0]    ttl_ms;
   logic [LEN_W-1:0]    byte_length;
   logic [2:0]          stat_select;
   logic                reset_after_read;

   modport source (output valid, opcode, partition, clear_all, key_tag, now_ms, ttl_ms,
                   byte_length, stat_select, reset_after_read, input ready);
   modport sink (input valid, opcode, partition, clear_all, key_tag, now_ms, ttl_ms,
                 byte_length, stat_select, reset_after_read, output ready);
endinterface

### rtl/core/ttl_lcd_rsp_if.sv
// ttl_lcd_rsp_if: response channel, valid/ready with the result fields
// depends on ttl_lcd_pkg

interface ttl_lcd_rsp_if;
   import ttl_lcd_pkg::*;

   logic                valid;
   logic                ready;
   logic [3:0]          status;
   logic [SLOT_W-1:0]   slot;
   logic [LEN_W-1:0]    stored_length;
   logic [STAT_W-1:0]   stat_value;

   modport source (output valid, status, slot, stored_length, stat_value, input ready);
   modport sink (input valid, status, slot, stored_length, stat_value, output ready);
endinterface

### rtl/core/ttl_lcd_ctrl.sv
// ttl_lcd_ctrl: sequencer for one request: accept, scan of the entry store where needed, drain, commit
// depends on ttl_lcd_pkg

module ttl_lcd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ttl_lcd_pkg::dp_status_type  dp_stat,
   output ttl_lcd_pkg::ctl_cmd_type    cmd
);
   import ttl_lcd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dp_stat.needs_scan ? S_SCAN : S_COMMIT;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (dp_stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_COMMIT;
         S_COMMIT: begin
            if (dp_stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/core/ttl_lcd_dpath.sv
// ttl_lcd_dpath: entry store, valid bits, scan accumulators, counters and response register
// depends on ttl_lcd_pkg; driven by ttl_lcd_ctrl

module ttl_lcd_dpath #(
   parameter int ENTRIES    = ttl_lcd_pkg::ENTRIES_DEF,
   parameter int VALUE_MAX  = ttl_lcd_pkg::VALUE_MAX_DEF,
   parameter int PARTITIONS = ttl_lcd_pkg::PARTITIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ttl_lcd_pkg::ctl_cmd_type            cmd,
   output ttl_lcd_pkg::dp_status_type          dp_stat,
   input  logic                                cfg_enable,
   input  logic [ttl_lcd_pkg::MASK_W-1:0]      cfg_mask,
   input  ttl_lcd_pkg::req_type                req_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output ttl_lcd_pkg::rsp_type                rsp_data
);
   import ttl_lcd_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   row_type            mem [ENTRIES];
   logic [ENTRIES-1:0] used_ff;

   req_type            req_ff, req_in;
   logic               ok_ff, ok_in;
   logic [IW-1:0]      addr_ff, addr_in;
   logic               rd_v_ff, rd_v_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   row_type            rd_row_ff;
   logic               match_ff, match_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   row_type            match_row_ff, match_row_in;
   logic               free_ff, free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               minv_ff, minv_in;
   logic [IW-1:0]      min_idx_ff, min_idx_in;
   logic [STAT_W-1:0]  min_stamp_ff, min_stamp_in;
   logic [CW-1:0]      live_ff, live_in;
   logic [STAT_W-1:0]  use_ff, use_in;
   logic [STAT_W-1:0]  cnt_ff [NUM_CNT];
   logic [STAT_W-1:0]  cnt_in [NUM_CNT];
   logic               rsp_v_ff, rsp_v_in;
   rsp_type            rsp_ff, rsp_in;

   logic               part_ok, ok_now, used_d, hit_d, clr_d;
   logic               wr_en, used_set, used_clr;
   logic [IW-1:0]      wr_idx, tgt;
   row_type            wr_row;
   logic [TIME_W:0]    exp_sum;
   logic [TIME_W-1:0]  exp_new;
   logic [STAT_W-1:0]  use_next;

   // acceptance decode on the incoming request
   always_comb begin
      part_ok = (32'(req_data.partition) < 32'(PARTITIONS)) &&
                (32'(req_data.partition) < 32'(MASK_W)) &&
                ((cfg_mask >> req_data.partition) & MASK_W'(1)) != '0;
      case (req_data.opcode)
         OP_LOOKUP:  ok_now = cfg_enable && part_ok;
         OP_STORE:   ok_now = cfg_enable && part_ok && (req_data.byte_length != '0) &&
                              (32'(req_data.byte_length) <= 32'(VALUE_MAX)) &&
                              (req_data.ttl_ms != '0);
         OP_CLEAR:   ok_now = req_data.clear_all ||
                              (32'(req_data.partition) < 32'(PARTITIONS));
         OP_STAT:    ok_now = 1'b1;
         OP_REFRESH: ok_now = 1'b1;
         default:    ok_now = 1'b0;
      endcase
      dp_stat.needs_scan = ok_now && ((req_data.opcode == OP_LOOKUP) ||
                           (req_data.opcode == OP_STORE) || (req_data.opcode == OP_CLEAR) ||
                           ((req_data.opcode == OP_STAT) && (req_data.stat_select == SEL_LIVE)));
      dp_stat.scan_last  = (addr_ff == IW'(ENTRIES - 1));
      dp_stat.out_free   = !rsp_v_ff || rsp_ready;
   end

   // per-entry evaluation of the returning read
   always_comb begin
      used_d = used_ff[rd_idx_ff];
      hit_d  = used_d && (rd_row_ff.part == req_ff.partition) && (rd_row_ff.key == req_ff.key_tag);
      clr_d  = rd_v_ff && ok_ff && (req_ff.opcode == OP_CLEAR) &&
               (req_ff.clear_all || (rd_row_ff.part == req_ff.partition));
   end

   always_comb begin
      req_in       = req_ff;
      ok_in        = ok_ff;
      addr_in      = addr_ff;
      rd_v_in      = cmd.scan;
      rd_idx_in    = addr_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_row_in = match_row_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      minv_in      = minv_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      live_in      = live_ff;
      use_in       = use_ff;
      cnt_in       = cnt_ff;
      rsp_v_in     = rsp_v_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_idx       = match_idx_ff;
      wr_row       = match_row_ff;
      used_set     = 1'b0;
      used_clr     = 1'b0;
      tgt          = match_idx_ff;
      use_next     = use_ff + STAT_W'(1);
      exp_sum      = {1'b0, req_ff.now_ms} + (TIME_W + 1)'(req_ff.ttl_ms);
      exp_new      = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

      if (cmd.load) begin
         req_in   = req_data;
         ok_in    = ok_now;
         addr_in  = '0;
         match_in = 1'b0;
         free_in  = 1'b0;
         minv_in  = 1'b0;
         live_in  = '0;
      end
      if (cmd.scan) addr_in = addr_ff + IW'(1);

      if (rd_v_ff) begin
         if (!match_ff && hit_d) begin
            match_in     = 1'b1;
            match_idx_in = rd_idx_ff;
            match_row_in = rd_row_ff;
         end
         if (!free_ff && !used_d) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if (!minv_ff || (rd_row_ff.stamp < min_stamp_ff)) begin
            minv_in      = 1'b1;
            min_idx_in   = rd_idx_ff;
            min_stamp_in = rd_row_ff.stamp;
         end
         if (used_d) live_in = live_ff + CW'(1);
      end

      if (cmd.commit) begin
         rsp_v_in = 1'b1;
         rsp_in   = '0;
         rsp_in.status = ST_REJECTED;
         if (ok_ff) begin
            case (req_ff.opcode)
               OP_LOOKUP: begin
                  if (!match_ff) begin
                     rsp_in.status = ST_MISS;
                     cnt_in[CNT_MISSES] = cnt_ff[CNT_MISSES] + STAT_W'(1);
                  end else if (match_row_ff.expiry <= req_ff.now_ms) begin
                     used_clr = 1'b1;
                     cnt_in[CNT_EXPIRATIONS] = cnt_ff[CNT_EXPIRATIONS] + STAT_W'(1);
                     cnt_in[CNT_MISSES] = cnt_ff[CNT_MISSES] + STAT_W'(1);
                     rsp_in.status = ST_EXPIRED;
                     rsp_in.slot   = SLOT_W'(match_idx_ff);
                  end else if (req_ff.byte_length < match_row_ff.len) begin
                     cnt_in[CNT_MISSES] = cnt_ff[CNT_MISSES] + STAT_W'(1);
                     rsp_in.status = ST_SMALL;
                     rsp_in.slot   = SLOT_W'(match_idx_ff);
                  end else begin
                     use_in       = use_next;
                     wr_en        = 1'b1;
                     wr_row.stamp = use_next;
                     cnt_in[CNT_HITS] = cnt_ff[CNT_HITS] + STAT_W'(1);
                     rsp_in.status        = ST_HIT;
                     rsp_in.slot          = SLOT_W'(match_idx_ff);
                     rsp_in.stored_length = match_row_ff.len;
                  end
               end
               OP_STORE: begin
                  if (match_ff) begin
                     tgt = match_idx_ff;
                     rsp_in.status = ST_UPDATED;
                  end else if (free_ff) begin
                     tgt = free_idx_ff;
                     rsp_in.status = ST_NEW;
                  end else begin
                     tgt = min_idx_ff;
                     rsp_in.status = ST_EVICTED;
                     cnt_in[CNT_EVICTIONS] = cnt_ff[CNT_EVICTIONS] + STAT_W'(1);
                  end
                  wr_en         = 1'b1;
                  wr_idx        = tgt;
                  wr_row.part   = req_ff.partition;
                  wr_row.key    = req_ff.key_tag;
                  wr_row.len    = req_ff.byte_length;
                  wr_row.expiry = exp_new;
                  wr_row.stamp  = use_next;
                  used_set      = 1'b1;
                  use_in        = use_next;
                  cnt_in[CNT_STORES] = cnt_ff[CNT_STORES] + STAT_W'(1);
                  rsp_in.slot   = SLOT_W'(tgt);
               end
               OP_CLEAR: begin
                  cnt_in[CNT_INVALIDATIONS] = cnt_ff[CNT_INVALIDATIONS] + STAT_W'(1);
                  rsp_in.status = ST_CLEARED;
               end
               OP_STAT: begin
                  if (req_ff.stat_select == SEL_LIVE) rsp_in.stat_value = STAT_W'(live_ff);
                  else                                rsp_in.stat_value = cnt_ff[req_ff.stat_select];
                  if (req_ff.reset_after_read)
                     for (int k = 0; k < NUM_CNT; k++) cnt_in[k] = '0;
                  rsp_in.status = ST_STAT;
               end
               OP_REFRESH: begin
                  cnt_in[CNT_REFRESHES] = cnt_ff[CNT_REFRESHES] + STAT_W'(1);
                  rsp_in.status = ST_REFRESH;
               end
               default: rsp_in.status = ST_REJECTED;
            endcase
         end
      end
   end

   // entry store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_row;
      rd_row_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         if (clr_d)    used_ff[rd_idx_ff] <= 1'b0;
         if (used_clr) used_ff[match_idx_ff] <= 1'b0;
         if (used_set) used_ff[tgt] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         use_ff   <= '0;
         for (int k = 0; k < NUM_CNT; k++) cnt_ff[k] <= '0;
      end else begin
         rd_v_ff  <= rd_v_in;
         rsp_v_ff <= rsp_v_in;
         use_ff   <= use_in;
         cnt_ff   <= cnt_in;
      end
      req_ff       <= req_in;
      ok_ff        <= ok_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_row_ff <= match_row_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      minv_ff      <= minv_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      live_ff      <= live_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/ttl_lru_cache_directory.sv
// ttl_lru_cache_directory: top level, channels, register port, controller and datapath
// depends on ttl_lcd_pkg, ttl_lcd_req_if, ttl_lcd_rsp_if, ttl_lcd_ctrl, ttl_lcd_dpath
//
//   port      role         handshake
//   req_ch    requests in  valid/ready, taken when both high
//   rsp_ch    results out  valid/ready, held until taken
//   p*        registers    apb write, setup then access, pready tied high
//
// accepted lookup, store, clear and live count requests sweep the entry store through
// the single read port, one entry a cycle; other and rejected requests skip the sweep
// a new request is taken once the previous result sits in the output register
// reset is synchronous; valid bits, counters and the use stamp clear at once

module ttl_lru_cache_directory #(
   parameter int ENTRIES    = ttl_lcd_pkg::ENTRIES_DEF,
   parameter int VALUE_MAX  = ttl_lcd_pkg::VALUE_MAX_DEF,
   parameter int PARTITIONS = ttl_lcd_pkg::PARTITIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ttl_lcd_req_if.sink                        req_ch,
   ttl_lcd_rsp_if.source                      rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ttl_lcd_pkg::CSR_AW-1:0]     paddr,
   input  logic [ttl_lcd_pkg::CSR_DW-1:0]     pwdata,
   output logic [ttl_lcd_pkg::CSR_DW-1:0]     prdata,
   output logic                               pready
);
   import ttl_lcd_pkg::*;

   logic               enable_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic               csr_wr;
   req_type            req_data;
   rsp_type            rsp_data;
   ctl_cmd_type        cmd;
   dp_status_type      dp_stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         mask_ff   <= '1;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_IDX_ENABLE: enable_ff <= pwdata[0];
            CSR_IDX_MASK:   mask_ff   <= pwdata[MASK_W-1:0];
            default:        enable_ff <= enable_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_MASK) ? CSR_DW'(mask_ff) : CSR_DW'(enable_ff);

   assign req_data.opcode           = req_ch.opcode;
   assign req_data.partition        = req_ch.partition;
   assign req_data.clear_all        = req_ch.clear_all;
   assign req_data.key_tag          = req_ch.key_tag;
   assign req_data.now_ms           = req_ch.now_ms;
   assign req_data.ttl_ms           = req_ch.ttl_ms;
   assign req_data.byte_length      = req_ch.byte_length;
   assign req_data.stat_select      = req_ch.stat_select;
   assign req_data.reset_after_read = req_ch.reset_after_read;

   assign rsp_ch.status        = rsp_data.status;
   assign rsp_ch.slot          = rsp_data.slot;
   assign rsp_ch.stored_length = rsp_data.stored_length;
   assign rsp_ch.stat_value    = rsp_data.stat_value;

   ttl_lcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   ttl_lcd_dpath #(
      .ENTRIES    (ENTRIES),
      .VALUE_MAX  (VALUE_MAX),
      .PARTITIONS (PARTITIONS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_stat    (dp_stat),
      .cfg_enable (enable_ff),
      .cfg_mask   (mask_ff),
      .req_data   (req_data),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/core/ttl_lcd_checker.sv
// ttl_lcd_rsp_checker: port-level checks on the result channel, bound to the top level
// depends on ttl_lcd_pkg and ttl_lru_cache_directory

module ttl_lcd_rsp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [3:0]                        rsp_status,
   input logic [ttl_lcd_pkg::SLOT_W-1:0]    rsp_slot,
   input logic [ttl_lcd_pkg::LEN_W-1:0]     rsp_len,
   input logic [ttl_lcd_pkg::STAT_W-1:0]    rsp_stat
);
   import ttl_lcd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_REFRESH)
      else $error("unknown status code");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT |-> rsp_len == '0)
      else $error("stored length outside a hit");

   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_REJECTED || rsp_status == ST_CLEARED) |->
      rsp_slot == '0 && rsp_stat == '0)
      else $error("rejected or cleared result carries data");

endmodule

bind ttl_lru_cache_directory ttl_lcd_rsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.slot),
   .rsp_len    (rsp_ch.stored_length),
   .rsp_stat   (rsp_ch.stat_value)
);

### verif/ttl_lcd_checker.sv
// ttl_lcd_checker: watches the request, result and register ports of the cache directory,
// predicts every result and compares it; depends on ttl_lcd_pkg and the channel interfaces
`timescale 1ns / 1ps

module ttl_lcd_checker
   import ttl_lcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ttl_lcd_req_if              req_ch,
   ttl_lcd_rsp_if              rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   input  logic                pready,
   output int                  fail_count,
   output int                  pending
);

   localparam int NSLOT = ENTRIES_DEF;
   localparam logic [TIME_W-1:0] EXPIRY_MAX = '1;
   localparam logic [CSR_AW-1:0] ADDR_ENABLE = CSR_AW'(4 * CSR_IDX_ENABLE);
   localparam logic [CSR_AW-1:0] ADDR_MASK   = CSR_AW'(4 * CSR_IDX_MASK);

   logic                enable_q;
   logic [MASK_W-1:0]   mask_q;
   logic                used_q   [NSLOT];
   logic [PART_W-1:0]   part_q   [NSLOT];
   logic [KEY_W-1:0]    key_q    [NSLOT];
   logic [LEN_W-1:0]    len_q    [NSLOT];
   logic [TIME_W-1:0]   expiry_q [NSLOT];
   logic [STAT_W-1:0]   stamp_q  [NSLOT];
   logic [STAT_W-1:0]   use_count;
   logic [STAT_W-1:0]   event_count [NUM_CNT];
   rsp_type             expected_rsp [$];

   function automatic logic partition_open(logic [PART_W-1:0] p);
      return (p < PARTITIONS_DEF) && mask_q[p];
   endfunction

   function automatic int find_entry(logic [PART_W-1:0] p, logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (used_q[i] && part_q[i] == p && key_q[i] == k) return i;
      return -1;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type          o;
      int               t;
      logic [STAT_W-1:0] live;
      o = '0;
      o.status = ST_REJECTED;
      case (r.opcode)
         OP_LOOKUP: begin
            if (enable_q && partition_open(r.partition)) begin
               t = find_entry(r.partition, r.key_tag);
               if (t < 0) begin
                  o.status = ST_MISS;
                  event_count[CNT_MISSES]++;
               end else if (expiry_q[t] <= r.now_ms) begin
                  used_q[t] = 1'b0;
                  event_count[CNT_EXPIRATIONS]++;
                  event_count[CNT_MISSES]++;
                  o.status = ST_EXPIRED;
                  o.slot = SLOT_W'(t);
               end else if (r.byte_length < len_q[t]) begin
                  event_count[CNT_MISSES]++;
                  o.status = ST_SMALL;
                  o.slot = SLOT_W'(t);
               end else begin
                  use_count++;
                  stamp_q[t] = use_count;
                  event_count[CNT_HITS]++;
                  o.status = ST_HIT;
                  o.slot = SLOT_W'(t);
                  o.stored_length = len_q[t];
               end
            end
         end
         OP_STORE: begin
            if (enable_q && partition_open(r.partition) && r.byte_length != 0 &&
                r.byte_length <= VALUE_MAX_DEF && r.ttl_ms != 0) begin
               t = find_entry(r.partition, r.key_tag);
               o.status = ST_UPDATED;
               if (t < 0) begin
                  o.status = ST_NEW;
                  for (int i = 0; i < NSLOT; i++)
                     if (!used_q[i]) begin
                        t = i;
                        break;
                     end
               end
               if (t < 0) begin
                  o.status = ST_EVICTED;
                  t = 0;
                  for (int i = 1; i < NSLOT; i++)
                     if (stamp_q[i] < stamp_q[t]) t = i;
                  event_count[CNT_EVICTIONS]++;
               end
               used_q[t] = 1'b1;
               part_q[t] = r.partition;
               key_q[t] = r.key_tag;
               len_q[t] = r.byte_length;
               expiry_q[t] = ({32'd0, r.ttl_ms} > {16'd0, EXPIRY_MAX - r.now_ms}) ?
                             EXPIRY_MAX : r.now_ms + TIME_W'(r.ttl_ms);
               use_count++;
               stamp_q[t] = use_count;
               event_count[CNT_STORES]++;
               o.slot = SLOT_W'(t);
            end
         end
         OP_CLEAR: begin
            if (r.clear_all || r.partition < PARTITIONS_DEF) begin
               for (int i = 0; i < NSLOT; i++)
                  if (r.clear_all || part_q[i] == r.partition) used_q[i] = 1'b0;
               event_count[CNT_INVALIDATIONS]++;
               o.status = ST_CLEARED;
            end
         end
         OP_STAT: begin
            if (r.stat_select != SEL_LIVE) begin
               o.stat_value = event_count[r.stat_select];
            end else begin
               live = '0;
               for (int i = 0; i < NSLOT; i++) live += used_q[i];
               o.stat_value = live;
            end
            if (r.reset_after_read)
               for (int c = 0; c < NUM_CNT; c++) event_count[c] = '0;
            o.status = ST_STAT;
         end
         OP_REFRESH: begin
            event_count[CNT_REFRESHES]++;
            o.status = ST_REFRESH;
         end
         default: ;
      endcase
      return o;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      req_type r;
      rsp_type e;
      if (reset) begin
         enable_q <= 1'b1;
         mask_q <= '1;
         for (int i = 0; i < NSLOT; i++) begin
            used_q[i] = 1'b0;
            part_q[i] = '0;
            key_q[i] = '0;
            len_q[i] = '0;
            expiry_q[i] = '0;
            stamp_q[i] = '0;
         end
         use_count = '0;
         for (int c = 0; c < NUM_CNT; c++) event_count[c] = '0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_ENABLE) enable_q <= pwdata[0];
            else if (paddr == ADDR_MASK) mask_q <= pwdata[MASK_W-1:0];
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result with no request outstanding: status %0d", rsp_ch.status);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
                  fail_count <= fail_count + 1;
               end
               if (rsp_ch.slot !== e.slot) begin
                  $error("slot: expected %0d, got %0d", e.slot, rsp_ch.slot);
                  fail_count <= fail_count + 1;
               end
               if (rsp_ch.stored_length !== e.stored_length) begin
                  $error("stored_length: expected %0d, got %0d", e.stored_length,
                         rsp_ch.stored_length);
                  fail_count <= fail_count + 1;
               end
               if (rsp_ch.stat_value !== e.stat_value) begin
                  $error("stat_value: expected %0d, got %0d", e.stat_value,
                         rsp_ch.stat_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            r.opcode = req_ch.opcode;
            r.partition = req_ch.partition;
            r.clear_all = req_ch.clear_all;
            r.key_tag = req_ch.key_tag;
            r.now_ms = req_ch.now_ms;
            r.ttl_ms = req_ch.ttl_ms;
            r.byte_length = req_ch.byte_length;
            r.stat_select = req_ch.stat_select;
            r.reset_after_read = req_ch.reset_after_read;
            expected_rsp.push_back(apply_request(r));
         end
      end
   end

endmodule

### verif/tb.sv
// tb: stimulus and verdict for ttl_lru_cache_directory; directed then random requests
// under several idle/stall mixes and register settings; depends on ttl_lcd_pkg,
// the channel interfaces, ttl_lcd_checker and the block itself
`timescale 1ns / 1ps

module tb;
   import ttl_lcd_pkg::*;

   localparam logic [CSR_AW-1:0] ADDR_ENABLE = CSR_AW'(4 * CSR_IDX_ENABLE);
   localparam logic [CSR_AW-1:0] ADDR_MASK   = CSR_AW'(4 * CSR_IDX_MASK);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  pending;
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   logic [TIME_W-1:0]   clock_ms = 48'd1000;
   logic [KEY_W-1:0]    key_pool [80];

   ttl_lcd_req_if req_ch ();
   ttl_lcd_rsp_if rsp_ch ();

   ttl_lru_cache_directory u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ttl_lcd_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_LOOKUP;
      req_ch.partition = '0;
      req_ch.clear_all = 1'b0;
      req_ch.key_tag = '0;
      req_ch.now_ms = '0;
      req_ch.ttl_ms = '0;
      req_ch.byte_length = '0;
      req_ch.stat_select = CNT_HITS;
      req_ch.reset_after_read = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(req_type r);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= r.opcode;
      req_ch.partition <= r.partition;
      req_ch.clear_all <= r.clear_all;
      req_ch.key_tag <= r.key_tag;
      req_ch.now_ms <= r.now_ms;
      req_ch.ttl_ms <= r.ttl_ms;
      req_ch.byte_length <= r.byte_length;
      req_ch.stat_select <= r.stat_select;
      req_ch.reset_after_read <= r.reset_after_read;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (ENTRIES_DEF + 10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_request(op_type op, logic [PART_W-1:0] p,
                                            logic [KEY_W-1:0] k, logic [TIME_W-1:0] now,
                                            logic [TTL_W-1:0] ttl, logic [LEN_W-1:0] len);
      req_type r;
      r = '0;
      r.opcode = op;
      r.partition = p;
      r.key_tag = k;
      r.now_ms = now;
      r.ttl_ms = ttl;
      r.byte_length = len;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.clear_all = $urandom_range(1);
      r.stat_select = sel_type'($urandom_range(7));
      r.reset_after_read = ($urandom_range(3) == 0);
      pick = $urandom_range(99);
      r.partition = ($urandom_range(19) == 0) ? PART_W'($urandom_range(6, 7))
                                              : PART_W'($urandom_range(5));
      r.key_tag = ($urandom_range(19) == 0) ? rand64() : key_pool[$urandom_range(79)];
      clock_ms = clock_ms + $urandom_range(20);
      r.now_ms = ($urandom_range(49) == 0) ? TIME_W'(rand64()) : clock_ms;
      case ($urandom_range(9))
         0: r.ttl_ms = $urandom;
         1: r.ttl_ms = '0;
         default: r.ttl_ms = $urandom_range(1, 400);
      endcase
      if (pick < 45) begin
         r.opcode = OP_STORE;
         r.byte_length = ($urandom_range(9) == 0) ? LEN_W'($urandom)
                                                  : LEN_W'($urandom_range(1, VALUE_MAX_DEF));
      end else begin
         r.opcode = (pick < 82) ? OP_LOOKUP :
                    (pick < 84) ? OP_CLEAR :
                    (pick < 91) ? OP_STAT :
                    (pick < 96) ? OP_REFRESH : op_type'($urandom_range(5, 7));
         r.byte_length = LEN_W'($urandom);
      end
      return r;
   endfunction

   initial begin
      req_type r;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 80; i++) key_pool[i] = rand64();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_request(make_request(OP_LOOKUP, 0, key_pool[1], 100, 0, 8191));
      send_request(make_request(OP_STORE, 0, key_pool[1], 100, 50, 4096));
      send_request(make_request(OP_STORE, 0, key_pool[1], 100, 50, 20));
      send_request(make_request(OP_LOOKUP, 0, key_pool[1], 120, 0, 20));
      send_request(make_request(OP_LOOKUP, 0, key_pool[1], 120, 0, 19));
      send_request(make_request(OP_LOOKUP, 0, key_pool[1], 150, 0, 8191));
      send_request(make_request(OP_STORE, 5, key_pool[0], '1, '1, 1));
      send_request(make_request(OP_LOOKUP, 5, key_pool[0], '1, 0, 8191));
      send_request(make_request(OP_STORE, 1, key_pool[2], 100, 0, 10));
      send_request(make_request(OP_STORE, 1, key_pool[2], 100, 9, 0));
      send_request(make_request(OP_STORE, 1, key_pool[2], 100, 9, 4097));
      send_request(make_request(OP_STORE, 6, key_pool[2], 100, 9, 10));
      send_request(make_request(OP_LOOKUP, 7, key_pool[2], 100, 9, 10));
      send_request(make_request(OP_STORE, 2, key_pool[3], 100, 900, 10));
      r = make_request(OP_CLEAR, 2, 0, 0, 0, 0);
      send_request(r);
      r.partition = 7;
      send_request(r);
      r.clear_all = 1'b1;
      send_request(r);
      send_request(make_request(OP_REFRESH, 7, 0, 0, 0, 0));
      for (int s = 0; s < 8; s++) begin
         r = make_request(OP_STAT, 0, 0, 0, 0, 0);
         r.stat_select = sel_type'(s);
         r.reset_after_read = (s == 7);
         send_request(r);
      end
      send_request(make_request(op_type'(5), 0, 0, 0, 0, 0));
      send_request(make_request(op_type'(7), 0, 0, 0, 0, 0));
      drain();
      write_csr(ADDR_MASK, 32'hFFFF_FFDE);
      send_request(make_request(OP_STORE, 0, key_pool[4], 100, 9, 10));
      send_request(make_request(OP_STORE, 5, key_pool[4], 100, 9, 10));
      drain();
      write_csr(ADDR_ENABLE, 32'hFFFF_FFFE);
      write_csr(ADDR_MASK, 32'h3F);
      send_request(make_request(OP_LOOKUP, 1, key_pool[4], 100, 9, 10));
      send_request(make_request(OP_STORE, 1, key_pool[4], 100, 9, 10));
      drain();
      write_csr(ADDR_ENABLE, 32'h1);

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 23; stall_pct = 23; end
         endcase
         for (int n = 0; n < 150; n++) begin
            send_request(random_request());
            if (n == 75) drain();
         end
         drain();
         case (ph)
            2: write_csr(ADDR_MASK, '0);
            3: write_csr(ADDR_MASK, $urandom);
            4: write_csr(ADDR_ENABLE, '0);
            5: write_csr(ADDR_ENABLE, 32'h1);
            default: write_csr(ADDR_MASK, 32'h3F);
         endcase
      end
      drain();
      if (fail_count == 0)
         $display("** ttl_lru_cache_directory: PASSED **");
      else
         $display("** ttl_lru_cache_directory: FAILED **");
      $finish;
   end

   initial begin
      #60ms;
      $display("** ttl_lru_cache_directory: FAILED **");
      $finish;
   end

endmodule
